FILE: sv/mts_pkg.sv
package mts_pkg;

	// Default parameter values for the core
	localparam int TAG_LOOKAHEAD_DEF = 4;
	localparam int DEPTH_BITS_DEF = 8;

	// Tag table: one row per tag name, padded with zero to the widest lookahead
	localparam int NUM_TAGS = 6;
	localparam int TAG_SPAN = 4;
	localparam logic [7:0] TAG_TXT [NUM_TAGS][TAG_SPAN] = '{
		'{8'h62, 8'h72, 8'h00, 8'h00},	// br
		'{8'h70, 8'h3E, 8'h00, 8'h00},	// p>
		'{8'h70, 8'h20, 8'h00, 8'h00},	// p + space
		'{8'h2F, 8'h70, 8'h3E, 8'h00},	// /p>
		'{8'h64, 8'h69, 8'h76, 8'h00},	// div
		'{8'h6C, 8'h69, 8'h00, 8'h00}	// li
	};
	localparam logic [2:0] TAG_LEN [NUM_TAGS] = '{3'd2, 3'd2, 3'd2, 3'd3, 3'd3, 3'd2};

	// Entity table: text, length and decoded character
	localparam int NUM_ENTS = 5;
	localparam int ENT_MAXLEN = 6;
	localparam logic [7:0] ENT_TXT [NUM_ENTS][ENT_MAXLEN] = '{
		'{8'h26, 8'h6E, 8'h62, 8'h73, 8'h70, 8'h3B},	// &nbsp;
		'{8'h26, 8'h6C, 8'h74, 8'h3B, 8'h00, 8'h00},	// &lt;
		'{8'h26, 8'h67, 8'h74, 8'h3B, 8'h00, 8'h00},	// &gt;
		'{8'h26, 8'h71, 8'h75, 8'h6F, 8'h74, 8'h3B},	// &quot;
		'{8'h26, 8'h61, 8'h6D, 8'h70, 8'h3B, 8'h00}	// &amp;
	};
	localparam logic [2:0] ENT_LEN [NUM_ENTS] = '{3'd6, 3'd4, 3'd4, 3'd6, 3'd5};
	localparam logic [7:0] ENT_CHR [NUM_ENTS] = '{8'h20, 8'h3C, 8'h3E, 8'h22, 8'h26};

	// Held bytes are always a strict prefix of an entity
	localparam int HOLD_MAX = ENT_MAXLEN - 1;
	// Results of one item: tail, held bytes, newline, one decoded byte
	localparam int RES_MAX = HOLD_MAX + 3;

	// Result queue
	localparam int FIFO_DEPTH = 32;
	localparam int FIFO_ROOM = 2 * RES_MAX;

	// Characters
	localparam logic [7:0] CH_LT = 8'h3C;
	localparam logic [7:0] CH_GT = 8'h3E;
	localparam logic [7:0] CH_AMP = 8'h26;
	localparam logic [7:0] CH_NL = 8'h0A;
	localparam logic [7:0] CH_UP_A = 8'h41;
	localparam logic [7:0] CH_UP_Z = 8'h5A;
	localparam logic [7:0] CASE_OFS = 8'h20;

	typedef struct packed {
		logic [7:0] data;
		logic last;
	} res_t;

endpackage

FILE: sv/mts_ifs.sv
interface mts_in_if;
	logic valid;
	logic ready;
	logic [7:0] in_byte;
	logic in_last;

	modport source (output valid, output in_byte, output in_last, input ready);
	modport sink (input valid, input in_byte, input in_last, output ready);
endinterface

interface mts_out_if;
	logic valid;
	logic ready;
	logic [7:0] out_byte;
	logic out_last;

	modport source (output valid, output out_byte, output out_last, input ready);
	modport sink (input valid, input out_byte, input out_last, output ready);
endinterface

FILE: sv/markup_tag_stripper_core.sv
// The results of an item pass the input register, then enter the 32-entry result queue and
// leave it one per cycle while the output is ready; the newest result byte waits as tail
// until the next kept byte or the end of the text decides its last flag.
// Throughput: one item per cycle while the queue holds at most 16 entries (up to 8
// results per item are written together); the output drains one result per cycle while ready.
// Reset (arst_n low, asynchronous): empty queue, depth zero, no tag check, no held bytes.
module markup_tag_stripper_core
	import mts_pkg::*;
#(
	parameter int TAG_LOOKAHEAD = TAG_LOOKAHEAD_DEF,
	parameter int DEPTH_BITS = DEPTH_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	mts_in_if.sink text_in,
	mts_out_if.source text_out
);

	localparam int OFF_W = $clog2(TAG_SPAN);
	localparam logic [DEPTH_BITS-1:0] DEPTH_MAX = '1;
	localparam int HC_W = $clog2(HOLD_MAX + 1);
	localparam int HI_W = $clog2(HOLD_MAX);
	localparam int N_W = $clog2(RES_MAX + 1);
	localparam int L_W = $clog2(RES_MAX);
	localparam int F_AW = $clog2(FIFO_DEPTH);
	localparam int F_CW = $clog2(FIFO_DEPTH + 1);
	localparam logic [F_CW-1:0] FILL_LIMIT = F_CW'(FIFO_DEPTH - FIFO_ROOM);

	// Input register
	logic valid_s1;
	logic [7:0] byte_s1;
	logic last_s1;

	// Stream state
	logic [DEPTH_BITS-1:0] depth_q;
	logic chk_valid_q;
	logic [OFF_W-1:0] chk_off_q;
	logic [NUM_TAGS-1:0] chk_mask_q;
	logic [7:0] held_q [HOLD_MAX];
	logic [HC_W-1:0] hcnt_q;
	logic [7:0] tail_q;
	logic tail_valid_q;

	// Result queue
	res_t fifo_q [FIFO_DEPTH];
	logic [F_AW-1:0] wr_ptr_q;
	logic [F_AW-1:0] rd_ptr_q;
	logic [F_CW-1:0] fcnt_q;

	// Step logic
	logic [7:0] low;
	logic [NUM_TAGS-1:0] mask_nx;
	logic hit;
	logic keep;
	logic fed;
	logic [HC_W-1:0] hp;
	logic full;
	logic pre;
	logic brk;
	logic emit_held;
	logic emit_y;
	logic [7:0] ent_y;
	logic [7:0] y_byte;
	logic [HC_W-1:0] hsel;
	logic [7:0] lst [RES_MAX];
	logic [N_W-1:0] n_res;
	logic [N_W-1:0] nm1;
	logic [N_W-1:0] npush;
	logic [N_W-1:0] push_n;
	logic pop;
	logic [HC_W-1:0] hcnt_nx;
	logic held_we;
	logic [HI_W-1:0] held_wi;
	logic [DEPTH_BITS-1:0] depth_nx;
	logic chk_valid_nx;
	logic [OFF_W-1:0] chk_off_nx;
	logic [NUM_TAGS-1:0] chk_mask_nx;
	logic tail_valid_nx;
	logic [7:0] tail_nx;

	// Accept while the queue can absorb two items' worth of results
	assign text_in.ready = fcnt_q <= FILL_LIMIT;

	// Advance the open tag check with the current byte
	always_comb begin
		int o1;
		logic any;
		low = byte_s1;
		if (byte_s1 >= CH_UP_A && byte_s1 <= CH_UP_Z) begin
			low = byte_s1 + CASE_OFS;
		end
		mask_nx = chk_mask_q;
		for (int t = 0; t < NUM_TAGS; t++) begin
			if (int'(chk_off_q) < int'(TAG_LEN[t]) && TAG_TXT[t][chk_off_q] != low) begin
				mask_nx[t] = 1'b0;
			end
		end
		o1 = int'(chk_off_q) + 1;
		any = 1'b0;
		for (int t = 0; t < NUM_TAGS; t++) begin
			if (mask_nx[t] && int'(TAG_LEN[t]) <= o1) begin
				any = 1'b1;
			end
		end
		hit = chk_valid_q && any;
		keep = chk_valid_q && !any && (mask_nx != '0) && (o1 < TAG_LOOKAHEAD);
		chk_off_nx = OFF_W'(o1);
	end

	// Match held bytes plus the new byte against the entity table
	always_comb begin
		logic ok;
		logic full_m;
		logic pre_m;
		logic [HC_W-1:0] hp1;
		fed = (depth_q == '0) && byte_s1 != CH_LT && byte_s1 != CH_GT;
		hp = hit ? '0 : hcnt_q;
		hp1 = hp + HC_W'(1);
		full_m = 1'b0;
		pre_m = 1'b0;
		ent_y = CH_AMP;
		for (int k = 0; k < NUM_ENTS; k++) begin
			ok = 1'b1;
			for (int i = 0; i < HOLD_MAX; i++) begin
				if (HC_W'(i) < hp && held_q[i] != ENT_TXT[k][i]) begin
					ok = 1'b0;
				end
			end
			if (ok && byte_s1 == ENT_TXT[k][hp]) begin
				if (hp1 == ENT_LEN[k]) begin
					full_m = 1'b1;
					ent_y = ENT_CHR[k];
				end else if (hp1 < ENT_LEN[k]) begin
					pre_m = 1'b1;
				end
			end
		end
		full = fed && full_m;
		pre = fed && pre_m && !full_m;
		brk = fed && !full_m && !pre_m;
		emit_held = hit || brk || (last_s1 && !full);
		emit_y = full || (fed && (last_s1 || (brk && byte_s1 != CH_AMP)));
		y_byte = full ? ent_y : byte_s1;
	end

	// Line up the sent bytes behind the tail: held bytes, newline, decoded byte
	always_comb begin
		logic [N_W-1:0] n0;
		logic [N_W-1:0] n1;
		lst = '{default: '0};
		if (tail_valid_q) begin
			lst[0] = tail_q;
		end
		hsel = emit_held ? hcnt_q : '0;
		for (int i = 0; i < HOLD_MAX; i++) begin
			if (HC_W'(i) < hsel) begin
				lst[L_W'(i + int'(tail_valid_q))] = held_q[i];
			end
		end
		n0 = N_W'(tail_valid_q) + N_W'(hsel);
		if (hit) begin
			lst[n0[L_W-1:0]] = CH_NL;
		end
		n1 = n0 + N_W'(hit);
		if (emit_y) begin
			lst[n1[L_W-1:0]] = y_byte;
		end
		n_res = n1 + N_W'(emit_y);
		nm1 = n_res - N_W'(1);
		if (last_s1) begin
			npush = n_res;
		end else if (n_res != '0) begin
			npush = nm1;
		end else begin
			npush = '0;
		end
		push_n = valid_s1 ? npush : '0;
	end

	// Next held bytes, depth, tag check and tail
	always_comb begin
		hcnt_nx = hit ? '0 : hcnt_q;
		held_we = 1'b0;
		held_wi = HI_W'(hp);
		if (fed) begin
			if (pre) begin
				hcnt_nx = hp + HC_W'(1);
				held_we = 1'b1;
			end else if (brk && byte_s1 == CH_AMP) begin
				hcnt_nx = HC_W'(1);
				held_we = 1'b1;
				held_wi = '0;
			end else begin
				hcnt_nx = '0;
			end
		end

		depth_nx = depth_q;
		if (byte_s1 == CH_LT) begin
			if (depth_q != DEPTH_MAX) begin
				depth_nx = depth_q + DEPTH_BITS'(1);
			end
		end else if (byte_s1 == CH_GT) begin
			if (depth_q != '0) begin
				depth_nx = depth_q - DEPTH_BITS'(1);
			end
		end

		chk_mask_nx = mask_nx;
		if (byte_s1 == CH_LT) begin
			chk_valid_nx = 1'b1;
			chk_mask_nx = '1;
		end else begin
			chk_valid_nx = keep;
		end

		tail_valid_nx = tail_valid_q;
		tail_nx = tail_q;
		if (!last_s1 && n_res != '0) begin
			tail_valid_nx = 1'b1;
			tail_nx = lst[nm1[L_W-1:0]];
		end

		// End of text: return the stream state to its reset values
		if (last_s1) begin
			hcnt_nx = '0;
			depth_nx = '0;
			chk_valid_nx = 1'b0;
			tail_valid_nx = 1'b0;
		end
	end

	assign pop = (fcnt_q != '0) && text_out.ready;

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			depth_q <= '0;
			chk_valid_q <= 1'b0;
			hcnt_q <= '0;
			tail_valid_q <= 1'b0;
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fcnt_q <= '0;
		end else begin
			valid_s1 <= text_in.valid && text_in.ready;
			if (valid_s1) begin
				depth_q <= depth_nx;
				chk_valid_q <= chk_valid_nx;
				hcnt_q <= hcnt_nx;
				tail_valid_q <= tail_valid_nx;
			end
			wr_ptr_q <= wr_ptr_q + F_AW'(push_n);
			rd_ptr_q <= rd_ptr_q + F_AW'(pop);
			fcnt_q <= fcnt_q + F_CW'(push_n) - F_CW'(pop);
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (text_in.valid && text_in.ready) begin
			byte_s1 <= text_in.in_byte;
			last_s1 <= text_in.in_last;
		end
		if (valid_s1) begin
			chk_off_q <= (byte_s1 == CH_LT) ? '0 : chk_off_nx;
			chk_mask_q <= chk_mask_nx;
			tail_q <= tail_nx;
			if (held_we) begin
				held_q[held_wi] <= byte_s1;
			end
		end
		// Write this item's results into the queue, last flag on the final one at end of text
		for (int j = 0; j < RES_MAX; j++) begin
			if (N_W'(j) < push_n) begin
				fifo_q[wr_ptr_q + F_AW'(j)] <= '{data: lst[j],
					last: last_s1 && (N_W'(j) == nm1)};
			end
		end
	end

	assign text_out.valid = fcnt_q != '0;
	assign text_out.out_byte = fifo_q[rd_ptr_q].data;
	assign text_out.out_last = fifo_q[rd_ptr_q].last;

endmodule

FILE: sv/mts_checker.sv
module mts_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic [7:0] out_byte,
	input logic out_last
);

	// Remember whether any item has come in since reset
	logic seen_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= 1'b0;
		end else if (in_valid && in_ready) begin
			seen_q <= 1'b1;
		end
	end

	a_reset_empty: assert property (@(posedge clk) !arst_n |-> !out_valid)
		else $error("result offered during reset");

	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> seen_q)
		else $error("result offered before any item was taken");

	a_ready_when_drained: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled while the result queue is empty");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(out_last))
		else $error("stalled result changed or vanished");

endmodule

bind markup_tag_stripper_core mts_checker u_mts_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(text_in.valid),
	.in_ready(text_in.ready),
	.out_valid(text_out.valid),
	.out_ready(text_out.ready),
	.out_byte(text_out.out_byte),
	.out_last(text_out.out_last)
);
